// File: sv/kst_pkg.sv
// Shared types and constants for the key sequence table matcher.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package kst_pkg;

  localparam int ACT_W  = 2;
  localparam int ENT_W  = 5;
  localparam int POS_W  = 4;
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_TERM     = 2'd0,
    ACT_WR_BYTE  = 2'd1,
    ACT_WR_LEN   = 2'd2
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR    = 2'd0,
    KIND_KEY     = 2'd1,
    KIND_UNKNOWN = 2'd2
  } kind_e;

  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_byte;
    logic wr_len;
    logic append;
    logic emit_char;
    logic cmp_first;
    logic cmp_next;
    logic next_entry;
    logic emit_match;
    logic emit_fallback;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fresh_printable;
    logic len_skip;
    logic byte_eq;
    logic last_byte;
    logic exact;
    logic last_entry;
  } status_t;

endpackage
`default_nettype wire

// File: sv/kst_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; used for the sequence bytes and the entry lengths.
`default_nettype none
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: sv/kst_datapath.sv
// Datapath of the key sequence table matcher: table memories, collected
// bytes, scan counters and result registers. Depends on kst_pkg and kst_ram.
`default_nettype none
module kst_datapath #(
  parameter int NUM_ENTRIES = 32,
  parameter int MAX_SEQ     = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [kst_pkg::ENT_W-1:0]       entry_index_i,
  input  wire logic [kst_pkg::POS_W-1:0]       byte_pos_i,
  input  wire logic [kst_pkg::BYTE_W-1:0]      byte_value_i,
  input  wire kst_pkg::cmd_t                   cmd_i,
  output kst_pkg::status_t                     status_o,
  output logic                                 result_valid_o,
  output logic [kst_pkg::KIND_W-1:0]           result_kind_o,
  output logic [kst_pkg::ENT_W-1:0]            key_index_o,
  output logic [kst_pkg::BYTE_W-1:0]           char_value_o
);
  import kst_pkg::*;

  localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int PW = $clog2(MAX_SEQ);
  localparam int LW = PW;
  localparam int CW = $clog2(MAX_SEQ + 1);
  localparam int SEQ_DEPTH = 1 << (EW + PW);
  localparam int LEN_DEPTH = 1 << EW;

  logic [BYTE_W-1:0]    col_q [MAX_SEQ];
  logic [BYTE_W-1:0]    first_q;
  logic [CW-1:0]        count_q;
  logic [EW-1:0]        n_q;
  logic [PW-1:0]        j_q;
  logic [LW-1:0]        len_q;
  logic [LEN_DEPTH-1:0] valid_q;
  logic                 out_valid_q;
  logic [KIND_W-1:0]    kind_q;
  logic [ENT_W-1:0]     idx_q;
  logic [BYTE_W-1:0]    char_q;

  logic                 ent_ok;
  logic                 pos_ok;
  logic [EW-1:0]        ent_idx;
  logic [PW-1:0]        pos_idx;
  logic [LW-1:0]        len_wval;
  logic [PW-1:0]        j_rd;
  logic [EW+PW-1:0]     seq_addr;
  logic                 seq_we;
  logic [BYTE_W-1:0]    seq_rdata;
  logic [EW-1:0]        len_addr;
  logic                 len_we;
  logic [LW-1:0]        len_rdata;
  logic [LW-1:0]        len_eff;
  logic                 printable;

  assign ent_ok   = int'(entry_index_i) < NUM_ENTRIES;
  assign pos_ok   = int'(byte_pos_i) < MAX_SEQ;
  assign ent_idx  = EW'(entry_index_i);
  assign pos_idx  = PW'(byte_pos_i);
  assign len_wval = (int'(byte_value_i) > MAX_SEQ - 1) ? LW'(MAX_SEQ - 1)
                                                       : LW'(byte_value_i);

  // The sequence memory is read one byte ahead of the compare.
  assign j_rd     = cmd_i.cmp_next ? j_q + PW'(1) : '0;
  assign seq_addr = cmd_i.wr_byte ? {ent_idx, pos_idx} : {n_q, j_rd};
  assign seq_we   = cmd_i.wr_byte && ent_ok && pos_ok;
  assign len_addr = cmd_i.wr_len ? ent_idx : n_q;
  assign len_we   = cmd_i.wr_len && ent_ok;

  kst_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SEQ_DEPTH)
  ) u_seq_ram (
    .clk_i   (clk_i),
    .we_i    (seq_we),
    .addr_i  (seq_addr),
    .wdata_i (byte_value_i),
    .rdata_o (seq_rdata)
  );

  kst_ram #(
    .WIDTH (LW),
    .DEPTH (LEN_DEPTH)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .addr_i  (len_addr),
    .wdata_i (len_wval),
    .rdata_o (len_rdata)
  );

  // An entry whose length was never written holds no sequence.
  assign len_eff   = valid_q[n_q] ? len_rdata : '0;
  assign printable = (byte_value_i >= CH_SPACE) && (byte_value_i <= CH_TILDE);

  always_comb begin
    status_o.fresh_printable = (count_q == '0) && printable;
    status_o.len_skip        = (len_eff == '0) || (count_q > CW'(len_eff));
    status_o.byte_eq         = col_q[j_q] == seq_rdata;
    status_o.last_byte       = (CW'(j_q) + CW'(1)) == count_q;
    status_o.exact           = count_q == CW'(len_q);
    status_o.last_entry      = n_q == EW'(NUM_ENTRIES - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      n_q         <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit_char || cmd_i.emit_match || cmd_i.emit_fallback;
      if (len_we) begin
        valid_q[ent_idx] <= 1'b1;
      end
      if (cmd_i.append) begin
        if (count_q == '0) begin
          count_q <= CW'(1);
          n_q     <= '0;
        end else if (count_q < CW'(MAX_SEQ)) begin
          count_q <= count_q + CW'(1);
        end
      end
      if (cmd_i.next_entry) begin
        n_q <= n_q + EW'(1);
      end
      if (cmd_i.emit_match || cmd_i.emit_fallback) begin
        count_q <= '0;
        n_q     <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      if (count_q == '0) begin
        col_q[0] <= byte_value_i;
        first_q  <= byte_value_i;
      end else if (count_q < CW'(MAX_SEQ)) begin
        col_q[count_q[PW-1:0]] <= byte_value_i;
      end
    end
    if (cmd_i.cmp_first) begin
      len_q <= len_eff;
      j_q   <= '0;
    end
    if (cmd_i.cmp_next) begin
      j_q <= j_q + PW'(1);
    end
    if (cmd_i.emit_char) begin
      kind_q <= KIND_CHAR;
      idx_q  <= '0;
      char_q <= byte_value_i;
    end
    if (cmd_i.emit_match) begin
      kind_q <= KIND_KEY;
      idx_q  <= ENT_W'(n_q);
      char_q <= '0;
    end
    if (cmd_i.emit_fallback) begin
      idx_q <= '0;
      if (first_q == CH_ESC) begin
        kind_q <= KIND_UNKNOWN;
        char_q <= '0;
      end else begin
        kind_q <= KIND_CHAR;
        char_q <= (first_q == CH_LF) ? CH_CR : first_q;
      end
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_kind_o  = kind_q;
  assign key_index_o    = idx_q;
  assign char_value_o   = char_q;

  // Every result ends a collection, so the collection is empty when it shows.
  a_result_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> count_q == '0)
    else $error("result shown while bytes are still collected");

  // A collection is only ever started by a non-printable byte.
  a_first_nonprint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> (first_q < CH_SPACE || first_q > CH_TILDE))
    else $error("collection started by a printable byte");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= EW'(NUM_ENTRIES - 1))
    else $error("scan position beyond the last entry");

endmodule
`default_nettype wire

// File: sv/kst_ctrl.sv
// Controller of the key sequence table matcher: sequences the entry scan
// and issues commands to the datapath. Depends on kst_pkg.
`default_nettype none
module kst_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [kst_pkg::ACT_W-1:0]  action_i,
  input  wire kst_pkg::status_t           status_i,
  output kst_pkg::cmd_t                   cmd_o,
  output logic                            busy_o
);
  import kst_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN_RD,
    S_LEN_CHK,
    S_CMP
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  logic   accept;

  assign accept = start_i && !busy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (action_e'(action_i))
            ACT_TERM: begin
              if (status_i.fresh_printable) begin
                cmd_o.emit_char = 1'b1;
              end else begin
                cmd_o.append = 1'b1;
                state_d      = S_LEN_RD;
              end
            end
            ACT_WR_BYTE: cmd_o.wr_byte = 1'b1;
            ACT_WR_LEN:  cmd_o.wr_len  = 1'b1;
            default: ;
          endcase
        end
      end
      S_LEN_RD: begin
        state_d = S_LEN_CHK;
      end
      S_LEN_CHK: begin
        if (status_i.len_skip) begin
          if (status_i.last_entry) begin
            cmd_o.emit_fallback = 1'b1;
            state_d             = S_IDLE;
          end else begin
            cmd_o.next_entry = 1'b1;
            state_d          = S_LEN_RD;
          end
        end else begin
          cmd_o.cmp_first = 1'b1;
          state_d         = S_CMP;
        end
      end
      S_CMP: begin
        if (!status_i.byte_eq) begin
          if (status_i.last_entry) begin
            cmd_o.emit_fallback = 1'b1;
            state_d             = S_IDLE;
          end else begin
            cmd_o.next_entry = 1'b1;
            state_d          = S_LEN_RD;
          end
        end else if (status_i.last_byte) begin
          // A proper prefix leaves the scan parked on this entry.
          cmd_o.emit_match = status_i.exact;
          state_d          = S_IDLE;
        end else begin
          cmd_o.cmp_next = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= state_d != S_IDLE;
    end
  end

  assign busy_o = busy_q;

  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.emit_char, cmd_o.emit_match, cmd_o.emit_fallback}))
    else $error("more than one result issued in a cycle");

  // Compares only follow a length check or an earlier compare.
  a_cmp_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> ($past(state_q) == S_LEN_CHK || $past(state_q) == S_CMP))
    else $error("compare entered without a length check");

endmodule
`default_nettype wire

// File: sv/key_sequence_table_matcher_core.sv
// Top level of the key sequence table matcher.
// Depends on kst_pkg, kst_ctrl, kst_datapath and kst_ram.
//
// Usage: an item (action, entry index, byte position, byte value) is taken
// at a rising edge where start_i is high and busy_o is low. Load items write
// a table byte or an entry length and give no result; busy_o stays low, so
// the next beat may follow in the next cycle. A printable terminal byte with
// nothing collected gives a plain-character result in the next cycle, also
// without raising busy_o.
// Any other terminal byte is appended to the collection and starts a scan
// of the table in the controller/datapath pair. Each entry scanned goes
// through a length read (S_LEN_RD, S_LEN_CHK) in the length memory and
// then a compare per byte (S_CMP) through the single port of the sequence
// memory, and busy_o stays high for the whole scan. A result, if any, shows
// on result_valid_o for one cycle, the first cycle in which busy_o is low
// again; a proper prefix gives no result and waits for the next
// terminal byte.
// The receiver cannot stall: each result beat is taken in the cycle it shows.
// Reset clears the collection, the scan position and all entry lengths; the
// table bytes stay undefined until loaded. No clearing pass is needed.
`default_nettype none
module key_sequence_table_matcher_core #(
  parameter int NUM_ENTRIES = 32,
  parameter int MAX_SEQ     = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [kst_pkg::ACT_W-1:0]     action_i,
  input  wire logic [kst_pkg::ENT_W-1:0]     entry_index_i,
  input  wire logic [kst_pkg::POS_W-1:0]     byte_pos_i,
  input  wire logic [kst_pkg::BYTE_W-1:0]    byte_value_i,
  output logic                               result_valid_o,
  output logic [kst_pkg::KIND_W-1:0]         result_kind_o,
  output logic [kst_pkg::ENT_W-1:0]          key_index_o,
  output logic [kst_pkg::BYTE_W-1:0]         char_value_o
);
  import kst_pkg::*;

  cmd_t    cmd;
  status_t status;

  kst_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  kst_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .MAX_SEQ     (MAX_SEQ)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_index_i  (entry_index_i),
    .byte_pos_i     (byte_pos_i),
    .byte_value_i   (byte_value_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_kind_o  (result_kind_o),
    .key_index_o    (key_index_o),
    .char_value_o   (char_value_o)
  );

endmodule
`default_nettype wire

// File: sim/key_match_checker.sv
// Checker for the key sequence table matcher: watches the item and result channels,
// decodes each accepted beat into the expected key result and compares it.
// Depends on kst_pkg for field widths, action codes and result kinds.
`timescale 1ns / 100ps
module key_match_checker #(
  parameter int NUM_ENTRIES = 32,
  parameter int MAX_SEQ     = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic                       busy_i,
  input  wire logic [kst_pkg::ACT_W-1:0]  action_i,
  input  wire logic [kst_pkg::ENT_W-1:0]  entry_index_i,
  input  wire logic [kst_pkg::POS_W-1:0]  byte_pos_i,
  input  wire logic [kst_pkg::BYTE_W-1:0] byte_value_i,
  input  wire logic                       result_valid_i,
  input  wire logic [kst_pkg::KIND_W-1:0] result_kind_i,
  input  wire logic [kst_pkg::ENT_W-1:0]  key_index_i,
  input  wire logic [kst_pkg::BYTE_W-1:0] char_value_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              chars_seen_o,
  output int                              keys_seen_o,
  output int                              unknown_seen_o
);
  import kst_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ENT_W-1:0]  key;
    logic [BYTE_W-1:0] ch;
  } key_result_t;

  key_result_t       expected_keys[$];
  logic [BYTE_W-1:0] table_bytes [NUM_ENTRIES][MAX_SEQ];
  int                table_len   [NUM_ENTRIES];
  logic [BYTE_W-1:0] held_bytes  [MAX_SEQ];
  int                held_count;
  int                scan_from;

  assign pending_o = expected_keys.size();

  // Walks the table from the remembered entry. A proper prefix parks the scan
  // there and gives nothing; falling off the end returns the first held byte.
  task automatic scan_table(output bit got, output key_result_t r);
    int  n;
    int  j;
    bit  same;
    bit  done;
    done = 1'b0;
    got  = 1'b0;
    r    = '0;
    for (n = scan_from; n < NUM_ENTRIES && !done; n++) begin
      if (table_len[n] != 0 && held_count <= table_len[n]) begin
        same = 1'b1;
        for (j = 0; j < held_count; j++) begin
          if (held_bytes[j] != table_bytes[n][j]) same = 1'b0;
        end
        if (same) begin
          done = 1'b1;
          if (held_count == table_len[n]) begin
            got        = 1'b1;
            r.kind     = KIND_KEY;
            r.key      = ENT_W'(n);
            held_count = 0;
            scan_from  = 0;
          end else begin
            scan_from = n;
          end
        end
      end
    end
    if (!done) begin
      got        = 1'b1;
      held_count = 0;
      scan_from  = 0;
      if (held_bytes[0] == CH_ESC) begin
        r.kind = KIND_UNKNOWN;
      end else begin
        r.kind = KIND_CHAR;
        r.ch   = (held_bytes[0] == CH_LF) ? CH_CR : held_bytes[0];
      end
    end
  endtask

  task automatic take_beat(logic [ACT_W-1:0] act, logic [ENT_W-1:0] ent,
                           logic [POS_W-1:0] pos, logic [BYTE_W-1:0] val);
    key_result_t r;
    bit          got;
    got = 1'b0;
    r   = '0;
    case (act)
      ACT_WR_BYTE: begin
        if (int'(ent) < NUM_ENTRIES && int'(pos) < MAX_SEQ) table_bytes[ent][pos] = val;
      end
      ACT_WR_LEN: begin
        if (int'(ent) < NUM_ENTRIES)
          table_len[ent] = (int'(val) > MAX_SEQ - 1) ? MAX_SEQ - 1 : int'(val);
      end
      ACT_TERM: begin
        if (held_count == 0 && val >= CH_SPACE && val <= CH_TILDE) begin
          got    = 1'b1;
          r.kind = KIND_CHAR;
          r.ch   = val;
        end else begin
          if (held_count == 0) scan_from = 0;
          if (held_count < MAX_SEQ) begin
            held_bytes[held_count] = val;
            held_count++;
          end
          scan_table(got, r);
        end
      end
      default: ;
    endcase
    if (got) expected_keys.push_back(r);
  endtask

  task automatic flag_mismatch(string what, key_result_t want, key_result_t seen);
    if (fail_count_o < 10)
      $display("%0t ns: %s: kind %0d/%0d, key %0d/%0d, char %02h/%02h (expected/actual)",
               $time, what, want.kind, seen.kind, want.key, seen.key, want.ch, seen.ch);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    key_result_t seen;
    key_result_t want;
    if (!rst_ni) begin
      expected_keys.delete();
      for (int e = 0; e < NUM_ENTRIES; e++) table_len[e] = 0;
      held_count     = 0;
      scan_from      = 0;
      fail_count_o   = 0;
      chars_seen_o   = 0;
      keys_seen_o    = 0;
      unknown_seen_o = 0;
    end else begin
      if (result_valid_i) begin
        seen = '{result_kind_i, key_index_i, char_value_i};
        case (seen.kind)
          KIND_CHAR: chars_seen_o++;
          KIND_KEY:  keys_seen_o++;
          default:   unknown_seen_o++;
        endcase
        if (expected_keys.size() == 0) begin
          flag_mismatch("result beat with nothing expected", '0, seen);
        end else begin
          want = expected_keys.pop_front();
          if (seen.kind !== want.kind || seen.key !== want.key || seen.ch !== want.ch)
            flag_mismatch("key result mismatch", want, seen);
        end
      end
      if (start_i && !busy_i)
        take_beat(action_i, entry_index_i, byte_pos_i, byte_value_i);
    end
  end
endmodule

// File: sim/testbench.sv
// Stimulus and verdict for the key sequence table matcher core.
// Depends on kst_pkg, key_sequence_table_matcher_core and key_match_checker.
`timescale 1ns / 100ps
module testbench;
  import kst_pkg::*;

  localparam int NUM_ENTRIES = 32;
  localparam int MAX_SEQ     = 16;
  localparam int PHASE_BEATS = 225;
  // Worst scan: every entry read and every byte compared, plus margin.
  localparam int SETTLE      = NUM_ENTRIES * (MAX_SEQ + 2) + 32;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [ACT_W-1:0]  action_i;
  logic [ENT_W-1:0]  entry_index_i;
  logic [POS_W-1:0]  byte_pos_i;
  logic [BYTE_W-1:0] byte_value_i;
  logic              result_valid_o;
  logic [KIND_W-1:0] result_kind_o;
  logic [ENT_W-1:0]  key_index_o;
  logic [BYTE_W-1:0] char_value_o;

  int fail_count;
  int pending;
  int chars_seen;
  int keys_seen;
  int unknown_seen;

  // What the stimulus has loaded, so that typed sequences hit real entries
  // and no length ever covers a table byte that was never written.
  logic [BYTE_W-1:0]  loaded_bytes [NUM_ENTRIES][MAX_SEQ];
  logic [MAX_SEQ-1:0] loaded_mask  [NUM_ENTRIES];
  int                 loaded_len   [NUM_ENTRIES];
  int                 idle_pct;
  int                 beats_sent;
  int                 term_sent;

  key_sequence_table_matcher_core #(
    .NUM_ENTRIES(NUM_ENTRIES),
    .MAX_SEQ    (MAX_SEQ)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .action_i      (action_i),
    .entry_index_i (entry_index_i),
    .byte_pos_i    (byte_pos_i),
    .byte_value_i  (byte_value_i),
    .result_valid_o(result_valid_o),
    .result_kind_o (result_kind_o),
    .key_index_o   (key_index_o),
    .char_value_o  (char_value_o)
  );

  key_match_checker #(
    .NUM_ENTRIES(NUM_ENTRIES),
    .MAX_SEQ    (MAX_SEQ)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .action_i      (action_i),
    .entry_index_i (entry_index_i),
    .byte_pos_i    (byte_pos_i),
    .byte_value_i  (byte_value_i),
    .result_valid_i(result_valid_o),
    .result_kind_i (result_kind_o),
    .key_index_i   (key_index_o),
    .char_value_i  (char_value_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .chars_seen_o  (chars_seen),
    .keys_seen_o   (keys_seen),
    .unknown_seen_o(unknown_seen)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // Drives one beat and returns in the time step of the edge that took it.
  task automatic issue(logic [ACT_W-1:0] act, int ent, int pos, int val);
    int gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 80) : $urandom_range(1, 3);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    action_i      <= act;
    entry_index_i <= ENT_W'(ent);
    byte_pos_i    <= POS_W'(pos);
    byte_value_i  <= BYTE_W'(val);
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    case (act)
      ACT_WR_BYTE: begin
        loaded_bytes[ent][pos] = BYTE_W'(val);
        loaded_mask[ent][pos]  = 1'b1;
      end
      ACT_WR_LEN: loaded_len[ent] = (val > MAX_SEQ - 1) ? MAX_SEQ - 1 : val;
      ACT_TERM:   term_sent++;
      default: ;
    endcase
    if (act != ACT_UNUSED) beats_sent++;
  endtask

  task automatic press(int val);
    issue(ACT_TERM, $urandom_range(0, NUM_ENTRIES - 1), $urandom_range(0, MAX_SEQ - 1), val);
  endtask

  // Any table byte the new length would expose gets written first.
  task automatic set_length(int ent, int val);
    int eff;
    eff = (val > MAX_SEQ - 1) ? MAX_SEQ - 1 : val;
    for (int p = 0; p < eff; p++) begin
      if (!loaded_mask[ent][p]) issue(ACT_WR_BYTE, ent, p, $urandom_range(0, 255));
    end
    issue(ACT_WR_LEN, ent, $urandom_range(0, MAX_SEQ - 1), val);
  endtask

  function automatic int lead_byte();
    if ($urandom_range(0, 3) != 0) return CH_ESC;
    return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 31) : $urandom_range(127, 255);
  endfunction

  // Loads an escape-style sequence, often sharing a prefix with another entry
  // so that the scan has to walk past near misses.
  task automatic load_sequence(int ent);
    int len;
    int base;
    int share;
    int b;
    len   = ($urandom_range(0, 9) == 0) ? MAX_SEQ - 1 : $urandom_range(1, 6);
    base  = $urandom_range(0, NUM_ENTRIES - 1);
    share = 0;
    if (loaded_len[base] > 0)
      share = $urandom_range(0, (len < loaded_len[base]) ? len : loaded_len[base]);
    for (int p = 0; p < len; p++) begin
      if (p < share)     b = loaded_bytes[base][p];
      else if (p == 0)   b = lead_byte();
      else               b = ($urandom_range(0, 1) == 0) ? $urandom_range(32, 126)
                                                         : $urandom_range(0, 255);
      issue(ACT_WR_BYTE, ent, p, b);
    end
    if (len == MAX_SEQ - 1 && $urandom_range(0, 1) == 0) set_length(ent, $urandom_range(16, 255));
    else                                                  set_length(ent, len);
  endtask

  // Types an entry in full, breaks it off after a prefix, or runs past it.
  task automatic type_entry(int ent);
    int mode;
    int cut;
    mode = $urandom_range(0, 5);
    cut  = loaded_len[ent];
    if (mode == 3 || mode == 4) cut = $urandom_range(1, loaded_len[ent]);
    for (int p = 0; p < cut; p++) press(loaded_bytes[ent][p]);
    if (mode >= 3) press($urandom_range(0, 255));
  endtask

  // Drops start_i and waits for an edge before polling, so the checker has already queued the last beat taken.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(int pct);
    int target;
    int pick;
    int ent;
    idle_pct = pct;
    target   = beats_sent + PHASE_BEATS;
    while (beats_sent < target) begin
      pick = $urandom_range(0, 99);
      ent  = $urandom_range(0, NUM_ENTRIES - 1);
      if (pick < 15) begin
        load_sequence(ent);
      end else if (pick < 62) begin
        for (int t = 0; t < 8 && loaded_len[ent] == 0; t++)
          ent = $urandom_range(0, NUM_ENTRIES - 1);
        if (loaded_len[ent] == 0) load_sequence(ent);
        else                      type_entry(ent);
      end else if (pick < 76) begin
        press(($urandom_range(0, 1) == 0) ? lead_byte() : $urandom_range(0, 255));
      end else if (pick < 85) begin
        issue(ACT_WR_BYTE, ent, $urandom_range(0, MAX_SEQ - 1), $urandom_range(0, 255));
      end else if (pick < 92) begin
        set_length(ent, ($urandom_range(0, 3) == 0) ? $urandom_range(16, 255)
                                                     : $urandom_range(0, MAX_SEQ - 1));
      end else if (pick < 96) begin
        issue(ACT_UNUSED, ent, $urandom_range(0, MAX_SEQ - 1), $urandom_range(0, 255));
      end else begin
        set_length(ent, 0);
      end
    end
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    action_i      = ACT_TERM;
    entry_index_i = '0;
    byte_pos_i    = '0;
    byte_value_i  = '0;
    idle_pct      = 0;
    beats_sent    = 0;
    term_sent     = 0;
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      loaded_mask[e] = '0;
      loaded_len[e]  = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: printable bounds, control bytes, NUL, LF and ESC alone.
    issue(ACT_TERM, 0, 0, 8'h41);
    issue(ACT_TERM, NUM_ENTRIES - 1, MAX_SEQ - 1, CH_SPACE);
    issue(ACT_TERM, 0, 0, CH_TILDE);
    issue(ACT_TERM, 0, 0, 8'h7F);
    issue(ACT_TERM, 0, 0, 8'h00);
    issue(ACT_TERM, 0, 0, 8'hFF);
    issue(ACT_TERM, 0, 0, CH_LF);
    issue(ACT_TERM, 0, 0, CH_ESC);
    issue(ACT_UNUSED, NUM_ENTRIES - 1, MAX_SEQ - 1, 8'hFF);
    // One three-byte entry: exact hit, broken tail, doubled escape, and a
    // length cut while the collection waits.
    issue(ACT_WR_BYTE, 1, 0, CH_ESC);
    issue(ACT_WR_BYTE, 1, 1, 8'h5B);
    issue(ACT_WR_BYTE, 1, 2, 8'h41);
    set_length(1, 3);
    issue(ACT_TERM, 0, 0, CH_ESC);
    issue(ACT_TERM, 0, 0, 8'h5B);
    issue(ACT_TERM, 0, 0, 8'h41);
    issue(ACT_TERM, 0, 0, CH_ESC);
    issue(ACT_TERM, 0, 0, 8'h5B);
    issue(ACT_TERM, 0, 0, 8'h78);
    issue(ACT_TERM, 0, 0, CH_ESC);
    issue(ACT_TERM, 0, 0, CH_ESC);
    issue(ACT_TERM, 0, 0, CH_ESC);
    issue(ACT_TERM, 0, 0, 8'h5B);
    set_length(1, 2);
    issue(ACT_TERM, 0, 0, 8'h41);
    set_length(1, 3);
    drain();

    // Oversized length on the last entry saturates to the longest sequence.
    set_length(NUM_ENTRIES - 1, 8'hFF);
    random_phase(0);
    random_phase(54);
    random_phase(0);
    random_phase(32);

    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("Drove %0d beats, %0d of them terminal bytes, in four pacing phases.",
             beats_sent, term_sent);
    $display("Results seen: %0d plain characters, %0d matched keys, %0d unknown escapes.",
             chars_seen, keys_seen, unknown_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
